/* src/nabg_pkg.sv */
package nabg_pkg;

    // Field widths fixed by the interface
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int GRID_DIM_W = 13;
    localparam int POST_W     = 16;
    localparam int INDEX_W    = 20;
    localparam int COORD_W    = 28;
    localparam int RESULT_W   = 32;
    localparam int OUT_FRAC_W = 16;

    // Register map, one 32-bit word per register
    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_NULL_VALUE  = 2'd2,
        REG_ENABLED     = 2'd3
    } reg_index_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_OUTSIDE  = 2'd2,
        ST_ALL_NULL = 2'd3
    } status_t;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Register reset values
    localparam logic [GRID_DIM_W-1:0] GRID_WIDTH_RST  = 13'd1440;
    localparam logic [GRID_DIM_W-1:0] GRID_HEIGHT_RST = 13'd721;
    localparam logic [POST_W-1:0]     NULL_VALUE_RST  = 16'h8000;
    localparam logic                  ENABLED_RST     = 1'b1;

    // Saturation limits of the 16.16 result
    localparam logic [RESULT_W-1:0] RESULT_MAX = 32'h7fff_ffff;
    localparam logic [RESULT_W-1:0] RESULT_MIN = 32'h8000_0000;

    // Divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic ovf;
    } div_status_t;

endpackage

/* src/null_aware_bilinear_grid_lookup.sv */
// Channel    Direction  Signals                                      Transfer when
// request    in         kind post_index post_value x_coord y_coord   req_valid && req_ready
// response   out        height_offset status                         rsp_valid && rsp_ready
// config     in         psel penable pwrite paddr pwdata prdata      psel && penable && pwrite
//
// A post write goes into the post memory at its transfer. A query that reports disabled or
// outside goes from the check state to the done state; a full query makes four reads from
// the single post memory read port, then runs the one-bit-per-cycle divider unless all are null.
// One item is in work at a time; req_ready is high only while the sequencer is idle.
// The response register holds a finished result until taken while the next item enters.
// rst_n resets control and the configuration registers; post memory is not cleared and
// POST_DEPTH must be a power of two, which the block does not enforce (addresses wrap on its width).
module null_aware_bilinear_grid_lookup #(
    parameter int POST_DEPTH = 1048576,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic                                  kind,
    input  logic [nabg_pkg::INDEX_W-1:0]          post_index,
    input  logic signed [nabg_pkg::POST_W-1:0]    post_value,
    input  logic [nabg_pkg::COORD_W-1:0]          x_coord,
    input  logic [nabg_pkg::COORD_W-1:0]          y_coord,
    // response channel
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output logic signed [nabg_pkg::RESULT_W-1:0]  height_offset,
    output logic [1:0]                            status,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [nabg_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [nabg_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [nabg_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    localparam int AW  = $clog2(POST_DEPTH);
    localparam int CRW = nabg_pkg::COORD_W;
    localparam int GDW = nabg_pkg::GRID_DIM_W;
    localparam int PSW = nabg_pkg::POST_W;
    localparam int RW  = nabg_pkg::RESULT_W;
    localparam int IW  = CRW - FRAC_BITS;
    localparam int CW  = (IW + 1 > GDW) ? IW + 1 : GDW;
    localparam int FW  = FRAC_BITS + 1;
    localparam int AFW = FRAC_BITS + 2;
    localparam int PW  = 2 * AFW;
    localparam int WW  = FRAC_BITS + 4;
    localparam int MW  = PSW + WW;
    localparam int NW  = MW + 2;
    localparam int DW  = WW + 2;
    localparam int YWW = IW + GDW;
    localparam int BW  = (AW > YWW + 1) ? AW : YWW + 1;
    localparam int READS = 4;

    localparam logic [CRW:0]   HALF_S      = (CRW + 1)'(1 << (FRAC_BITS - 1));
    localparam logic [AFW-1:0] ONE_S       = AFW'(1 << FRAC_BITS);
    localparam logic [2:0]     GATHER_LAST = 3'd5;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_BASE   = 8'b0000_0100,
        S_GATHER = 8'b0000_1000,
        S_SIGN   = 8'b0001_0000,
        S_DSTART = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [GDW-1:0] grid_width_reg;
    logic [GDW-1:0] grid_height_reg;
    logic [PSW-1:0] null_value_reg;
    logic           enabled_reg;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= nabg_pkg::GRID_WIDTH_RST;
            grid_height_reg <= nabg_pkg::GRID_HEIGHT_RST;
            null_value_reg  <= nabg_pkg::NULL_VALUE_RST;
            enabled_reg     <= nabg_pkg::ENABLED_RST;
        end
        else if (cfg_wr)
        begin
            case (nabg_pkg::reg_index_t'(paddr[nabg_pkg::CFG_ADDR_W-1:2]))
                nabg_pkg::REG_GRID_WIDTH:  grid_width_reg  <= pwdata[GDW-1:0];
                nabg_pkg::REG_GRID_HEIGHT: grid_height_reg <= pwdata[GDW-1:0];
                nabg_pkg::REG_NULL_VALUE:  null_value_reg  <= pwdata[PSW-1:0];
                nabg_pkg::REG_ENABLED:     enabled_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        case (nabg_pkg::reg_index_t'(paddr[nabg_pkg::CFG_ADDR_W-1:2]))
            nabg_pkg::REG_GRID_WIDTH:  prdata = nabg_pkg::CFG_DATA_W'(grid_width_reg);
            nabg_pkg::REG_GRID_HEIGHT: prdata = nabg_pkg::CFG_DATA_W'(grid_height_reg);
            nabg_pkg::REG_NULL_VALUE:  prdata = nabg_pkg::CFG_DATA_W'(null_value_reg);
            nabg_pkg::REG_ENABLED:     prdata = nabg_pkg::CFG_DATA_W'(enabled_reg);
            default:                   prdata = '0;
        endcase
    end

    // Request transfer
    logic req_xfer;
    logic mem_we;

    assign req_ready = (state_reg == S_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign mem_we    = req_xfer && (kind == nabg_pkg::KIND_WRITE);

    // Query datapath registers
    logic [CRW-1:0]           x_reg, y_reg;
    logic [IW-1:0]            x0_reg, y0_reg;
    logic [FW-1:0]            fx_reg, fy_reg;
    logic [BW-1:0]            base_reg;
    logic [2:0]               step_reg;
    logic signed [WW-1:0]     wa_reg, wb_reg;
    logic                     va_reg, vb_reg;
    logic signed [MW-1:0]     prod_reg;
    logic signed [NW-1:0]     n_reg;
    logic signed [DW-1:0]     d_reg;
    logic [NW-1:0]            an_reg;
    logic [DW-1:0]            ad_reg;
    logic                     neg_reg;
    logic [RW-1:0]            res_val_reg;
    nabg_pkg::status_t        res_st_reg;
    logic [RW-1:0]            height_offset_reg;
    nabg_pkg::status_t        status_reg;
    logic                     rsp_valid_reg;

    // Range check and corner cell
    logic [CRW:0]   rx_sum, ry_sum;
    logic [IW:0]    rx, ry;
    logic [GDW-1:0] w_m1, h_m1;
    logic [IW-1:0]  x_int, y_int;
    logic           step_x, step_y, outside;

    assign rx_sum  = {1'b0, x_reg} + HALF_S;
    assign ry_sum  = {1'b0, y_reg} + HALF_S;
    assign rx      = rx_sum[CRW:FRAC_BITS];
    assign ry      = ry_sum[CRW:FRAC_BITS];
    assign w_m1    = grid_width_reg - GDW'(1);
    assign h_m1    = grid_height_reg - GDW'(1);
    assign x_int   = x_reg[CRW-1:FRAC_BITS];
    assign y_int   = y_reg[CRW-1:FRAC_BITS];
    assign step_x  = (CW'(x_int) == CW'(w_m1));
    assign step_y  = (CW'(y_int) == CW'(h_m1));
    assign outside = (grid_width_reg < GDW'(2)) || (grid_height_reg < GDW'(2)) ||
                     (CW'(rx) > CW'(w_m1)) || (CW'(ry) > CW'(h_m1));

    // Base address of the corner cell
    logic [YWW-1:0] yw;
    assign yw = y0_reg * grid_width_reg;

    // Read address and bilinear weight for the corner selected by step
    logic [1:0]            corner;
    logic [GDW:0]          offset;
    logic [BW-1:0]         addr_full;
    logic                  mem_re;
    logic [AW-1:0]         raddr;
    logic signed [AFW-1:0] fa, fb;
    logic signed [PW-1:0]  wprod, wshift;

    assign corner    = step_reg[1:0];
    assign offset    = (corner[1] ? {1'b0, grid_width_reg} : '0) + (GDW + 1)'(corner[0]);
    assign addr_full = base_reg + BW'(offset);
    assign raddr     = AW'(addr_full);
    assign mem_re    = (state_reg == S_GATHER) && (step_reg < 3'(READS));
    assign fa        = corner[0] ? signed'({1'b0, fx_reg}) : signed'(ONE_S - {1'b0, fx_reg});
    assign fb        = corner[1] ? signed'({1'b0, fy_reg}) : signed'(ONE_S - {1'b0, fy_reg});
    assign wprod     = fa * fb;
    assign wshift    = wprod >>> FRAC_BITS;

    // Null masking of the returned post
    logic [PSW-1:0]        ram_rdata;
    logic                  is_null;
    logic signed [WW-1:0]  w_masked;
    logic signed [PSW-1:0] post_s;

    assign is_null  = (ram_rdata == null_value_reg);
    assign w_masked = is_null ? '0 : wa_reg;
    assign post_s   = signed'(ram_rdata);

    nabg_post_ram #(
        .DEPTH  (POST_DEPTH),
        .ADDR_W (AW),
        .DATA_W (PSW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(post_index)),
        .wdata (post_value),
        .re    (mem_re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Normalizing divide
    logic                   div_start;
    logic [RW:0]            div_quo;
    nabg_pkg::div_status_t  div_stat;

    assign div_start = (state_reg == S_DSTART);

    nabg_divider #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (an_reg),
        .den   (ad_reg),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    // Round the magnitude half up, then saturate and apply sign
    logic [RW:0]   q_sum;
    logic [RW-1:0] q_mag;
    logic          q_sat;
    logic [RW-1:0] q_final;

    assign q_sum   = {1'b0, div_quo[RW-1:0]} + (RW + 1)'(1);
    assign q_mag   = q_sum[RW:1];
    assign q_sat   = div_stat.ovf || div_quo[RW] || (&div_quo[RW-1:0]);
    assign q_final = q_sat ? (neg_reg ? nabg_pkg::RESULT_MIN : nabg_pkg::RESULT_MAX)
                           : (neg_reg ? -q_mag : q_mag);

    // Sequencer
    logic rsp_free;
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (req_xfer && (kind == nabg_pkg::KIND_QUERY))
                begin
                    state_next = S_CHECK;
                end
            S_CHECK:
                if (!enabled_reg || outside)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_BASE;
                end
            S_BASE:
                state_next = S_GATHER;
            S_GATHER:
                if (step_reg == GATHER_LAST)
                begin
                    state_next = S_SIGN;
                end
            S_SIGN:
                if (d_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DSTART;
                end
            S_DSTART:
                state_next = S_DIV;
            S_DIV:
                if (div_stat.done)
                begin
                    state_next = S_DONE;
                end
            S_DONE:
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // advance the read and accumulate pipeline
            va_reg    <= mem_re;
            vb_reg    <= va_reg;
            if (state_reg == S_GATHER)
            begin
                step_reg <= step_reg + 3'd1;
            end
            else
            begin
                step_reg <= '0;
            end
        end
    end

    // Query datapath
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            x_reg <= x_coord;
            y_reg <= y_coord;
        end

        // step back on the last column or row
        if (state_reg == S_CHECK)
        begin
            x0_reg <= step_x ? x_int - IW'(1) : x_int;
            y0_reg <= step_y ? y_int - IW'(1) : y_int;
            fx_reg <= {step_x, x_reg[FRAC_BITS-1:0]};
            fy_reg <= {step_y, y_reg[FRAC_BITS-1:0]};
            res_val_reg <= '0;
            res_st_reg  <= !enabled_reg ? nabg_pkg::ST_DISABLED : nabg_pkg::ST_OUTSIDE;
        end

        if (state_reg == S_BASE)
        begin
            base_reg <= BW'(yw) + BW'(x0_reg);
            n_reg    <= '0;
            d_reg    <= '0;
        end

        // stage A: weight of the corner being read
        if (mem_re)
        begin
            wa_reg <= wshift[WW-1:0];
        end

        // stage B: mask null posts, form post times weight
        if (va_reg)
        begin
            prod_reg <= post_s * w_masked;
            wb_reg   <= w_masked;
        end

        // stage C: accumulate numerator and weight total
        if (vb_reg)
        begin
            n_reg <= n_reg + {{(NW - MW){prod_reg[MW-1]}}, prod_reg};
            d_reg <= d_reg + {{(DW - WW){wb_reg[WW-1]}}, wb_reg};
        end

        if (state_reg == S_SIGN)
        begin
            an_reg      <= n_reg[NW-1] ? -n_reg : n_reg;
            ad_reg      <= d_reg[DW-1] ? -d_reg : d_reg;
            neg_reg     <= n_reg[NW-1] ^ d_reg[DW-1];
            res_val_reg <= '0;
            res_st_reg  <= nabg_pkg::ST_ALL_NULL;
        end

        if ((state_reg == S_DIV) && div_stat.done)
        begin
            res_val_reg <= q_final;
            res_st_reg  <= nabg_pkg::ST_OK;
        end

        // hold the response until it is taken
        if ((state_reg == S_DONE) && rsp_free)
        begin
            height_offset_reg <= res_val_reg;
            status_reg        <= res_st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_DONE) && rsp_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign height_offset = height_offset_reg;
    assign status        = status_reg;

    // Pipeline is drained before the sign and divide steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIGN) |-> (!va_reg && !vb_reg))
        else $error("gather pipeline still busy at sign step");

    // Divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider result arrived outside divide wait");

    // Reads stay within the four corners
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GATHER) |-> (step_reg <= GATHER_LAST))
        else $error("gather step counter overran");

    // Any non-ok status carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status != 2'(nabg_pkg::ST_OK))) |-> (height_offset == '0))
        else $error("non-ok response with nonzero value");

endmodule

/* src/nabg_post_ram.sv */
module nabg_post_ram #(
    parameter int DEPTH  = 1048576,
    parameter int ADDR_W = 20,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/nabg_divider.sv */
module nabg_divider #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 22
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [NUM_W-1:0]             num,
    input  logic [DEN_W-1:0]             den,
    output logic [nabg_pkg::RESULT_W:0]  quo,
    output nabg_pkg::div_status_t        stat
);

    // Quotient of num * 2^(OUT_FRAC_W+1) / den, one bit per cycle
    localparam int QUO_W = nabg_pkg::RESULT_W + 1;
    localparam int PAD_W = nabg_pkg::OUT_FRAC_W + 1;
    localparam int LOW_W = QUO_W - PAD_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [QUO_W-1:0] bits_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;
    logic             take;

    // Trial subtract of the divisor from the shifted remainder
    assign shifted = {rem_reg, bits_reg[QUO_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign take    = !trial[DEN_W+1];

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: load high part of the dividend, then shift in the low bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den;
            rem_reg  <= DEN_W'(num >> LOW_W);
            ovf_reg  <= (num >> LOW_W) >= NUM_W'(den);
            bits_reg <= {num[LOW_W-1:0], PAD_W'(0)};
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            bits_reg <= {bits_reg[QUO_W-2:0], take};
        end
    end

    assign quo       = bits_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule
